// ===== sv/lltd_pkg.sv =====
// ----------------------------------------------------------------------------
// Least-loaded dispatcher package
// Shared constants, result status codes and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package lltd_pkg;

  localparam int NumWorkersDefault = 4;
  localparam int QueueDepthDefault = 16;

  localparam int TagWidth   = 16;
  localparam int EntryWidth = TagWidth + 1;

  typedef enum logic [1:0] {
    STATUS_ASSIGNED = 2'd0,
    STATUS_REJECTED = 2'd1,
    STATUS_DRAINED  = 2'd2,
    STATUS_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUBMIT,
    S_EMPTY,
    S_SCAN,
    S_OUT
  } state_e;

endpackage

`default_nettype wire

// ===== sv/least_loaded_task_dispatcher_core.sv =====
// ----------------------------------------------------------------------------
// Least-loaded task dispatcher core
// Places tasks in per-worker circular queues held in one task memory and
// drains every queue in reverse order on request.
// ----------------------------------------------------------------------------
// Submit: the command is registered ahead of the memory write and the result
// register; no new transaction is taken until the result has been registered.
// Drain: each drained item takes a memory read, then the result register,
// plus a scan step per worker whose queue is passed over once empty.
// Reset clears queue heads, counts and the task total; the task memory is
// not cleared, since only occupied slots are ever read.
`default_nettype none

module least_loaded_task_dispatcher_core
  import lltd_pkg::*;
#(
  parameter int NUM_WORKERS = NumWorkersDefault,
  parameter int QUEUE_DEPTH = QueueDepthDefault,
  localparam int IdxW = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1,
  localparam int CntW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                mode_i,
  input  wire logic [TagWidth-1:0] process_tag_i,
  input  wire logic                is_urgent_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [1:0]               status_o,
  output logic [IdxW-1:0]          worker_index_o,
  output logic [CntW-1:0]          worker_count_o,
  output logic [TagWidth-1:0]      out_tag_o,
  output logic                     out_urgent_o,
  output logic                     last_o
);

  localparam int StoreDepth = NUM_WORKERS * QUEUE_DEPTH;
  localparam int HeadW      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int AddrW      = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int TotW       = $clog2(StoreDepth + 1);
  localparam int SumW       = CntW + 1;

  state_e state_q, state_d;

  logic [CntW-1:0]  cnt_q  [NUM_WORKERS];
  logic [HeadW-1:0] head_q [NUM_WORKERS];
  logic [TotW-1:0]  total_q;
  logic [IdxW-1:0]  wkr_q;

  logic [TagWidth-1:0] tag_q;
  logic                urg_q;

  logic [EntryWidth-1:0] store_q [StoreDepth];
  logic [EntryWidth-1:0] rdata_q;

  logic                  out_valid_q;
  status_e               status_q;
  logic [IdxW-1:0]       oidx_q;
  logic [CntW-1:0]       ocnt_q;
  logic [TagWidth-1:0]   otag_q;
  logic                  ourg_q;
  logic                  olast_q;

  logic out_free;
  logic in_acc;

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_acc   = in_valid_i && !in_stall_o;

  // Least-loaded selection: ties go to the highest index.
  logic [NUM_WORKERS-1:0] win;
  logic [IdxW-1:0]        best;

  always_comb begin
    for (int w = 0; w < NUM_WORKERS; w++) begin
      win[w] = 1'b1;
      for (int v = 0; v < NUM_WORKERS; v++) begin
        if (v < w) begin
          if (cnt_q[w] > cnt_q[v]) win[w] = 1'b0;
        end else if (v > w) begin
          if (cnt_q[w] >= cnt_q[v]) win[w] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    best = '0;
    for (int w = 0; w < NUM_WORKERS; w++) begin
      if (win[w]) best = best | IdxW'(w);
    end
  end

  logic [CntW-1:0]  best_cnt;
  logic [HeadW-1:0] best_head;
  logic             best_full;
  logic [HeadW-1:0] urg_head;
  logic [SumW-1:0]  tail_sum;
  logic [HeadW-1:0] tail_slot;
  logic [HeadW-1:0] ins_slot;

  assign best_cnt  = cnt_q[best];
  assign best_head = head_q[best];
  assign best_full = best_cnt >= CntW'(QUEUE_DEPTH);
  assign urg_head  = (best_head == '0) ? HeadW'(QUEUE_DEPTH - 1) : best_head - HeadW'(1);
  assign tail_sum  = SumW'(best_head) + SumW'(best_cnt);
  assign tail_slot = (tail_sum >= SumW'(QUEUE_DEPTH)) ?
                     HeadW'(tail_sum - SumW'(QUEUE_DEPTH)) : HeadW'(tail_sum);
  assign ins_slot  = urg_q ? urg_head : tail_slot;

  // Drain scan addressing: last occupied slot of the current worker.
  logic [CntW-1:0]  scan_cnt;
  logic [HeadW-1:0] scan_head;
  logic [SumW-1:0]  scan_sum;
  logic [HeadW-1:0] scan_slot;

  assign scan_cnt  = cnt_q[wkr_q];
  assign scan_head = head_q[wkr_q];
  assign scan_sum  = SumW'(scan_head) + SumW'(scan_cnt) - SumW'(1);
  assign scan_slot = (scan_sum >= SumW'(QUEUE_DEPTH)) ?
                     HeadW'(scan_sum - SumW'(QUEUE_DEPTH)) : HeadW'(scan_sum);

  logic [AddrW-1:0] waddr;
  logic [AddrW-1:0] raddr;

  assign waddr = AddrW'(int'(best) * QUEUE_DEPTH + int'(ins_slot));
  assign raddr = AddrW'(int'(wkr_q) * QUEUE_DEPTH + int'(scan_slot));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (!mode_i) begin
            state_d = S_SUBMIT;
          end else if (total_q == '0) begin
            state_d = S_EMPTY;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SUBMIT: begin
        if (out_free) state_d = S_IDLE;
      end
      S_EMPTY: begin
        if (out_free) state_d = S_IDLE;
      end
      S_SCAN: begin
        if (scan_cnt != '0) begin
          state_d = S_OUT;
        end else if (wkr_q == '0) begin
          state_d = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_free) state_d = S_SCAN;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control outputs.
  logic sub_go, sub_we, empty_go, rd_go, skip_go, out_go;

  always_comb begin
    in_stall_o = 1'b1;
    sub_go     = 1'b0;
    sub_we     = 1'b0;
    empty_go   = 1'b0;
    rd_go      = 1'b0;
    skip_go    = 1'b0;
    out_go     = 1'b0;
    case (state_q)
      S_IDLE:   in_stall_o = 1'b0;
      S_SUBMIT: begin
        sub_go = out_free;
        sub_we = out_free && !best_full;
      end
      S_EMPTY:  empty_go = out_free;
      S_SCAN: begin
        rd_go   = scan_cnt != '0;
        skip_go = scan_cnt == '0;
      end
      S_OUT:    out_go = out_free;
      default:  in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (sub_we) store_q[waddr] <= {urg_q, tag_q};
    if (rd_go) rdata_q <= store_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tag_q <= process_tag_i;
      urg_q <= is_urgent_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      total_q <= '0;
      wkr_q   <= '0;
      for (int w = 0; w < NUM_WORKERS; w++) begin
        cnt_q[w]  <= '0;
        head_q[w] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (in_acc && mode_i) wkr_q <= IdxW'(NUM_WORKERS - 1);
      if (sub_we) begin
        cnt_q[best] <= best_cnt + CntW'(1);
        total_q     <= total_q + TotW'(1);
        if (urg_q) head_q[best] <= urg_head;
      end
      if (rd_go) begin
        cnt_q[wkr_q] <= scan_cnt - CntW'(1);
        total_q      <= total_q - TotW'(1);
      end
      if (skip_go) begin
        head_q[wkr_q] <= '0;
        if (wkr_q != '0) wkr_q <= wkr_q - IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (sub_go || empty_go || out_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sub_go) begin
      status_q <= best_full ? STATUS_REJECTED : STATUS_ASSIGNED;
      oidx_q   <= best;
      ocnt_q   <= best_full ? best_cnt : best_cnt + CntW'(1);
      otag_q   <= tag_q;
      ourg_q   <= urg_q;
      olast_q  <= 1'b1;
    end else if (empty_go) begin
      status_q <= STATUS_EMPTY;
      oidx_q   <= '0;
      ocnt_q   <= '0;
      otag_q   <= '0;
      ourg_q   <= 1'b0;
      olast_q  <= 1'b1;
    end else if (out_go) begin
      status_q <= STATUS_DRAINED;
      oidx_q   <= wkr_q;
      ocnt_q   <= scan_cnt;
      otag_q   <= rdata_q[TagWidth-1:0];
      ourg_q   <= rdata_q[TagWidth];
      olast_q  <= total_q == '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign worker_index_o = oidx_q;
  assign worker_count_o = ocnt_q;
  assign out_tag_o      = otag_q;
  assign out_urgent_o   = ourg_q;
  assign last_o         = olast_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TotW'(StoreDepth))
    else $error("Task total exceeds the store size.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT |-> $past(state_q) == S_SCAN || $past(state_q) == S_OUT)
    else $error("Drain output stage entered without a memory read.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_we |-> state_q == S_SUBMIT && !rd_go)
    else $error("Task memory written outside a submit.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN && state_d == S_IDLE |=> total_q == '0)
    else $error("Drain finished with tasks still queued.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_go |=> out_valid_o && status_o == STATUS_DRAINED)
    else $error("Drained item not presented.");

endmodule

`default_nettype wire

// ===== bench/least_loaded_task_dispatcher_core_test.sv =====
// ----------------------------------------------------------------------------
// Least-loaded task dispatcher core testbench
// Drives submit and drain transactions through the valid/stall input channel,
// predicts every result with a behavioral queue model kept in step with each
// accepted transaction, and compares each accepted result field by field. The
// run covers directed corner cases and random traffic under several idling
// mixes, plus a long output hold that backs the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module least_loaded_task_dispatcher_core_test;
  import lltd_pkg::*;

  localparam int NumWorkers   = NumWorkersDefault;
  localparam int QueueDepth   = QueueDepthDefault;
  localparam int IdxW         = (NumWorkers > 1) ? $clog2(NumWorkers) : 1;
  localparam int CntW         = $clog2(QueueDepth + 1);
  localparam int SlotCount    = NumWorkers * QueueDepth;
  localparam int DrainLatency = 2 * SlotCount + NumWorkers + 8;
  localparam int HoldCycles   = 300;
  localparam int CycleLimit   = 500000;
  localparam logic ModeSubmit = 1'b0;
  localparam logic ModeDrain  = 1'b1;

  typedef struct packed {
    status_e             status;
    logic [IdxW-1:0]     worker;
    logic [CntW-1:0]     count;
    logic [TagWidth-1:0] tag;
    logic                urgent;
    logic                last;
  } dispatch_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                mode_i = 1'b0;
  logic [TagWidth-1:0] process_tag_i = '0;
  logic                is_urgent_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [1:0]          status_o;
  logic [IdxW-1:0]     worker_index_o;
  logic [CntW-1:0]     worker_count_o;
  logic [TagWidth-1:0] out_tag_o;
  logic                out_urgent_o;
  logic                last_o;

  logic [EntryWidth-1:0] model_slots [SlotCount];
  int                    model_head  [NumWorkers];
  int                    model_fill  [NumWorkers];
  dispatch_result_t      pending_results [$];

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;
  int   mismatch_count = 0;
  int   cycle_count = 0;

  least_loaded_task_dispatcher_core #(
    .NUM_WORKERS(NumWorkers),
    .QUEUE_DEPTH(QueueDepth)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .process_tag_i (process_tag_i),
    .is_urgent_i   (is_urgent_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .worker_index_o(worker_index_o),
    .worker_count_o(worker_count_o),
    .out_tag_o     (out_tag_o),
    .out_urgent_o  (out_urgent_o),
    .last_o        (last_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic push_result(input status_e status, input int worker, input int count,
                             input logic [TagWidth-1:0] tag, input logic urgent,
                             input logic last);
    dispatch_result_t r;
    r.status = status;
    r.worker = IdxW'(worker);
    r.count  = CntW'(count);
    r.tag    = tag;
    r.urgent = urgent;
    r.last   = last;
    pending_results.push_back(r);
  endtask

  task automatic predict_dispatch(input logic mode, input logic [TagWidth-1:0] tag,
                                  input logic urgent);
    int best;
    int slot;
    int total;
    int produced;
    logic [EntryWidth-1:0] entry;
    if (mode == ModeSubmit) begin
      best = 0;
      for (int w = 0; w < NumWorkers; w++) begin
        if (model_fill[w] <= model_fill[best]) best = w;
      end
      if (model_fill[best] >= QueueDepth) begin
        push_result(STATUS_REJECTED, best, model_fill[best], tag, urgent, 1'b1);
      end else begin
        if (urgent) begin
          model_head[best] = (model_head[best] + QueueDepth - 1) % QueueDepth;
          slot = model_head[best];
        end else begin
          slot = (model_head[best] + model_fill[best]) % QueueDepth;
        end
        model_slots[best * QueueDepth + slot] = {urgent, tag};
        model_fill[best]++;
        push_result(STATUS_ASSIGNED, best, model_fill[best], tag, urgent, 1'b1);
      end
    end else begin
      total = 0;
      produced = 0;
      for (int w = 0; w < NumWorkers; w++) total += model_fill[w];
      if (total == 0) begin
        push_result(STATUS_EMPTY, 0, 0, '0, 1'b0, 1'b1);
      end else begin
        for (int w = NumWorkers - 1; w >= 0; w--) begin
          for (int k = model_fill[w] - 1; k >= 0; k--) begin
            slot = (model_head[w] + k) % QueueDepth;
            entry = model_slots[w * QueueDepth + slot];
            produced++;
            push_result(STATUS_DRAINED, w, k, entry[TagWidth-1:0], entry[TagWidth],
                        produced == total);
          end
          model_fill[w] = 0;
          model_head[w] = 0;
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    dispatch_result_t got;
    dispatch_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.status = status_e'(status_o);
      got.worker = worker_index_o;
      got.count  = worker_count_o;
      got.tag    = out_tag_o;
      got.urgent = out_urgent_o;
      got.last   = last_o;
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("Unexpected result: status %0d worker %0d count %0d tag %h urgent %b last %b",
                   got.status, got.worker, got.count, got.tag, got.urgent, got.last);
        end
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          if (mismatch_count < 10) begin
            $display("Mismatch at cycle %0d:", cycle_count);
            $display("  expected status %0d worker %0d count %0d tag %h urgent %b last %b",
                     want.status, want.worker, want.count, want.tag, want.urgent, want.last);
            $display("  actual   status %0d worker %0d count %0d tag %h urgent %b last %b",
                     got.status, got.worker, got.count, got.tag, got.urgent, got.last);
          end
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_item(input logic mode, input logic [TagWidth-1:0] tag,
                           input logic urgent);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= mode;
    process_tag_i <= tag;
    is_urgent_i   <= urgent;
    do @(posedge clk_i); while (in_stall_o);
    predict_dispatch(mode, tag, urgent);
  endtask

  task automatic send_random_submit();
    send_item(ModeSubmit, TagWidth'($urandom), 1'($urandom_range(1)));
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_drain();
    send_item(ModeDrain, 16'hFFFF, 1'b1);
    send_item(ModeDrain, 16'h0000, 1'b0);
  endtask

  task automatic test_tie_and_priority();
    send_item(ModeSubmit, 16'h0000, 1'b0);
    send_item(ModeSubmit, 16'hFFFF, 1'b1);
    send_item(ModeSubmit, 16'h1234, 1'b0);
    send_item(ModeSubmit, 16'hA5A5, 1'b1);
    send_item(ModeSubmit, 16'h5A5A, 1'b1);
    send_item(ModeSubmit, 16'h0F0F, 1'b0);
    send_item(ModeSubmit, 16'hF0F0, 1'b1);
    send_item(ModeSubmit, 16'h8001, 1'b0);
    send_item(ModeSubmit, 16'h7FFE, 1'b1);
    send_item(ModeSubmit, 16'h00FF, 1'b0);
    send_item(ModeDrain, 16'h3C3C, 1'b1);
    send_item(ModeDrain, 16'hC3C3, 1'b0);
    send_item(ModeSubmit, 16'hBEEF, 1'b1);
    send_item(ModeSubmit, 16'hCAFE, 1'b1);
    send_item(ModeDrain, 16'h0001, 1'b0);
  endtask

  task automatic test_full_reject();
    for (int i = 0; i < SlotCount; i++) send_random_submit();
    send_item(ModeSubmit, 16'hFFFF, 1'b1);
    send_item(ModeSubmit, 16'h0000, 1'b0);
    send_item(ModeDrain, TagWidth'($urandom), 1'($urandom_range(1)));
  endtask

  task automatic test_random_traffic(input int items, input int idle_pct,
                                     input int stall_pct);
    int sent;
    int burst;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < items) begin
      burst = ($urandom_range(9) == 0) ? $urandom_range(40, SlotCount + 6)
                                       : $urandom_range(0, 20);
      for (int i = 0; i < burst && sent < items; i++) begin
        send_random_submit();
        sent++;
      end
      send_item(ModeDrain, TagWidth'($urandom), 1'($urandom_range(1)));
      sent++;
    end
    wait_for_results();
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req = ~hold_req;
    for (int i = 0; i < 30; i++) send_random_submit();
    send_item(ModeDrain, TagWidth'($urandom), 1'($urandom_range(1)));
    wait_for_results();
    for (int i = 0; i < 4; i++) send_random_submit();
    send_item(ModeDrain, TagWidth'($urandom), 1'($urandom_range(1)));
    wait_for_results();
  endtask

  initial begin
    int leftover;
    for (int w = 0; w < NumWorkers; w++) begin
      model_head[w] = 0;
      model_fill[w] = 0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_drain();
    test_tie_and_priority();
    test_full_reject();
    test_random_traffic(90, 0, 0);
    test_random_traffic(90, 62, 0);
    test_random_traffic(90, 0, 62);
    test_random_traffic(90, 33, 33);
    test_backpressure();

    wait_for_results();
    repeat (DrainLatency) @(posedge clk_i);

    leftover = pending_results.size();
    if (leftover != 0) begin
      $display("%0d expected results never arrived", leftover);
    end
    if (mismatch_count == 0 && leftover == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
